/* hdl/cpi_pkg.sv */
// Shared types and constants for the circle pair intersection pipeline.
package cpi_pkg;

    localparam int LP_SQRT_STEPS = 64;
    localparam int LP_DIV_STEPS  = 64;
    localparam int LP_NUM_DIVS   = 4;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // geometry that rides along the whole pipe
    typedef struct packed {
        logic [1:0]  count;
        logic [31:0] x1;
        logic [31:0] y1;
        logic        dx_neg;
        logic        dy_neg;
        logic        dy_pos;
        logic        k_neg;
        logic [32:0] dxm;
        logic [32:0] dym;
        logic [63:0] d;
        logic [63:0] kmag;
    } t_geo;

    typedef struct packed {
        logic [127:0] rad;
        logic [65:0]  rem;
        logic [63:0]  root;
    } t_sqrt;

    // lanes: 0 px offset, 1 py offset, 2 nx, 3 ny
    typedef struct packed {
        logic [LP_NUM_DIVS-1:0][63:0] r;
        logic [LP_NUM_DIVS-1:0][63:0] nq;
    } t_div;

endpackage

/* hdl/cpi_front.sv */
// Front end: differences, squares, classification, K and the radicand Q.
module cpi_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [31:0]   i_x1,
    input  logic [31:0]   i_y1,
    input  logic [30:0]   i_r1,
    input  logic [31:0]   i_x2,
    input  logic [31:0]   i_y2,
    input  logic [30:0]   i_r2,
    output logic          o_vld,
    output cpi_pkg::t_geo o_geo,
    output logic [127:0]  o_q
);
    import cpi_pkg::*;

    logic [7:0]   r_vld;
    logic [31:0]  r_s1_x1, r_s1_y1;
    logic [32:0]  r_s1_dx, r_s1_dy;
    logic [31:0]  r_s1_sum, r_s2_sum;
    logic [30:0]  r_s1_dif, r_s1_r1, r_s1_r2, r_s2_dif, r_s2_r1, r_s2_r2;
    t_geo         r_g2, r_g3, r_g4, r_g5, r_g6, r_g7, r_g8;
    t_geo         n_g2, n_g5, n_g6, n_g8;
    logic [65:0]  r_s3_dxsq, r_s3_dysq, r_s4_dd;
    logic [63:0]  r_s3_sumsq, r_s4_sumsq, r_s5_a, r_s5_b;
    logic [61:0]  r_s3_difsq, r_s3_r1sq, r_s3_r2sq;
    logic [61:0]  r_s4_difsq, r_s4_r1sq, r_s4_r2sq, r_s5_r2sq;
    logic [66:0]  r_s5_t;
    logic [63:0]  r_s6_ll, r_s6_lh, r_s6_hl, r_s6_hh;
    logic [127:0] r_s7_q, r_s8_q;
    logic         w_bad, w_kneg, w_touch;
    logic [66:0]  w_kdiff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:0], i_vld};
        end
    end

    always_comb begin
        w_bad = (r_s4_dd == 66'd0) || (r_s4_dd > {2'b0, r_s4_sumsq})
             || (r_s4_dd < {4'b0, r_s4_difsq});
        w_kneg  = r_s5_t < {5'b0, r_s5_r2sq};
        w_kdiff = w_kneg ? ({5'b0, r_s5_r2sq} - r_s5_t) : (r_s5_t - {5'b0, r_s5_r2sq});
        w_touch = r_s7_q < {62'b0, r_g7.d, 2'b00};

        n_g2        = '0;
        n_g2.x1     = r_s1_x1;
        n_g2.y1     = r_s1_y1;
        n_g2.dx_neg = r_s1_dx[32];
        n_g2.dy_neg = r_s1_dy[32];
        n_g2.dy_pos = !r_s1_dy[32] && (r_s1_dy != 33'd0);
        n_g2.dxm    = r_s1_dx[32] ? (33'd0 - r_s1_dx) : r_s1_dx;
        n_g2.dym    = r_s1_dy[32] ? (33'd0 - r_s1_dy) : r_s1_dy;

        n_g5       = r_g4;
        n_g5.count = w_bad ? CNT_NONE : CNT_TWO;
        n_g5.d     = r_s4_dd[63:0];

        n_g6       = r_g5;
        n_g6.k_neg = w_kneg;
        n_g6.kmag  = w_kdiff[63:0];

        n_g8 = r_g7;
        if (r_g7.count != CNT_NONE && w_touch) begin
            n_g8.count = CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        // S1: center differences, radius sum and difference
        r_s1_x1  <= i_x1;
        r_s1_y1  <= i_y1;
        r_s1_dx  <= {i_x2[31], i_x2} - {i_x1[31], i_x1};
        r_s1_dy  <= {i_y2[31], i_y2} - {i_y1[31], i_y1};
        r_s1_sum <= {1'b0, i_r1} + {1'b0, i_r2};
        r_s1_dif <= (i_r1 > i_r2) ? (i_r1 - i_r2) : (i_r2 - i_r1);
        r_s1_r1  <= i_r1;
        r_s1_r2  <= i_r2;
        // S2: magnitudes and signs
        r_g2     <= n_g2;
        r_s2_sum <= r_s1_sum;
        r_s2_dif <= r_s1_dif;
        r_s2_r1  <= r_s1_r1;
        r_s2_r2  <= r_s1_r2;
        // S3: squares
        r_g3       <= r_g2;
        r_s3_dxsq  <= 66'(r_g2.dxm) * 66'(r_g2.dxm);
        r_s3_dysq  <= 66'(r_g2.dym) * 66'(r_g2.dym);
        r_s3_sumsq <= 64'(r_s2_sum) * 64'(r_s2_sum);
        r_s3_difsq <= 62'(r_s2_dif) * 62'(r_s2_dif);
        r_s3_r1sq  <= 62'(r_s2_r1) * 62'(r_s2_r1);
        r_s3_r2sq  <= 62'(r_s2_r2) * 62'(r_s2_r2);
        // S4: squared distance
        r_g4       <= r_g3;
        r_s4_dd    <= r_s3_dxsq + r_s3_dysq;
        r_s4_sumsq <= r_s3_sumsq;
        r_s4_difsq <= r_s3_difsq;
        r_s4_r1sq  <= r_s3_r1sq;
        r_s4_r2sq  <= r_s3_r2sq;
        // S5: classify, factors of Q, r1^2 + D
        r_g5      <= n_g5;
        r_s5_a    <= r_s4_sumsq - r_s4_dd[63:0];
        r_s5_b    <= r_s4_dd[63:0] - {2'b0, r_s4_difsq};
        r_s5_t    <= {1'b0, r_s4_dd} + {5'b0, r_s4_r1sq};
        r_s5_r2sq <= r_s4_r2sq;
        // S6: K and partial products of Q
        r_g6    <= n_g6;
        r_s6_ll <= 64'(r_s5_a[31:0]) * 64'(r_s5_b[31:0]);
        r_s6_lh <= 64'(r_s5_a[31:0]) * 64'(r_s5_b[63:32]);
        r_s6_hl <= 64'(r_s5_a[63:32]) * 64'(r_s5_b[31:0]);
        r_s6_hh <= 64'(r_s5_a[63:32]) * 64'(r_s5_b[63:32]);
        // S7: Q
        r_g7   <= r_g6;
        r_s7_q <= 128'(r_s6_ll) + (128'(r_s6_lh) << 32) + (128'(r_s6_hl) << 32)
                + (128'(r_s6_hh) << 64);
        // S8: touching when Q < 4D
        r_g8   <= n_g8;
        r_s8_q <= r_s7_q;
    end

    assign o_vld = r_vld[7];
    assign o_geo = r_g8;
    assign o_q   = r_s8_q;

endmodule

/* hdl/cpi_sqrt_cell.sv */
// One digit step of the pipelined integer square root.
module cpi_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  cpi_pkg::t_geo  i_geo,
    input  cpi_pkg::t_sqrt i_st,
    output logic           o_vld,
    output cpi_pkg::t_geo  o_geo,
    output cpi_pkg::t_sqrt o_st
);
    import cpi_pkg::*;

    logic  [67:0] w_rem, w_trial, w_diff;
    logic         w_ge;
    logic         r_vld;
    t_geo         r_geo;
    t_sqrt        r_st;

    always_comb begin
        w_rem   = {i_st.rem, i_st.rad[127:126]};
        w_trial = {2'b0, i_st.root, 2'b01};
        w_ge    = w_rem >= w_trial;
        w_diff  = w_rem - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_geo      <= i_geo;
        r_st.rad   <= {i_st.rad[125:0], 2'b00};
        r_st.rem   <= w_ge ? w_diff[65:0] : w_rem[65:0];
        r_st.root  <= {i_st.root[62:0], w_ge};
    end

    assign o_vld = r_vld;
    assign o_geo = r_geo;
    assign o_st  = r_st;

endmodule

/* hdl/cpi_div_cell.sv */
// One restoring step of the four parallel divisions by D.
module cpi_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  cpi_pkg::t_geo i_geo,
    input  cpi_pkg::t_div i_st,
    output logic          o_vld,
    output cpi_pkg::t_geo o_geo,
    output cpi_pkg::t_div o_st
);
    import cpi_pkg::*;

    logic [64:0] w_t [LP_NUM_DIVS];
    logic [64:0] w_s [LP_NUM_DIVS];
    logic [LP_NUM_DIVS-1:0] w_ge;
    logic        r_vld;
    t_geo        r_geo;
    t_div        r_st;

    always_comb begin
        for (int j = 0; j < LP_NUM_DIVS; j++) begin
            w_t[j]  = {i_st.r[j], i_st.nq[j][63]};
            w_ge[j] = w_t[j] >= {1'b0, i_geo.d};
            w_s[j]  = w_t[j] - {1'b0, i_geo.d};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_geo <= i_geo;
        for (int j = 0; j < LP_NUM_DIVS; j++) begin
            r_st.r[j]  <= w_ge[j] ? w_s[j][63:0] : w_t[j][63:0];
            r_st.nq[j] <= {i_st.nq[j][62:0], w_ge[j]};
        end
    end

    assign o_vld = r_vld;
    assign o_geo = r_geo;
    assign o_st  = r_st;

endmodule

/* hdl/cpi_back.sv */
// Back end: rounding of the quotients, point sums, saturation, result register.
module cpi_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  cpi_pkg::t_geo i_geo,
    input  cpi_pkg::t_div i_st,
    output logic          o_strobe,
    output logic [1:0]    o_point_count,
    output logic [31:0]   o_point_a_x,
    output logic [31:0]   o_point_a_y,
    output logic [31:0]   o_point_b_x,
    output logic [31:0]   o_point_b_y
);
    import cpi_pkg::*;

    function automatic logic [31:0] sat32(input logic [65:0] v);
        logic [31:0] res;
        if (!v[65] && (v[64:31] != '0)) begin
            res = 32'h7FFF_FFFF;
        end else if (v[65] && (v[64:31] != '1)) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    logic [64:0] w_rnd [LP_NUM_DIVS];
    logic [65:0] w_off [LP_NUM_DIVS];
    logic [65:0] w_xe, w_ye;
    logic        w_sub;
    logic        r_f1_vld, r_strobe;
    logic [1:0]  r_f1_cnt, r_cnt;
    logic [65:0] r_px, r_py, r_nx, r_ny;
    logic [31:0] r_ax, r_ay, r_bx, r_by;
    logic [31:0] n_ax, n_ay, n_bx, n_by;

    always_comb begin
        for (int j = 0; j < LP_NUM_DIVS; j++) begin
            w_rnd[j] = {1'b0, i_st.nq[j]} + 65'd1;
            w_off[j] = {2'b0, w_rnd[j][64:1]};
        end
        w_xe  = {{34{i_geo.x1[31]}}, i_geo.x1};
        w_ye  = {{34{i_geo.y1[31]}}, i_geo.y1};
        w_sub = i_geo.k_neg;

        n_ax = '0;
        n_ay = '0;
        n_bx = '0;
        n_by = '0;
        if (r_f1_cnt == CNT_ONE) begin
            n_ax = sat32(r_px);
            n_ay = sat32(r_py);
        end else if (r_f1_cnt == CNT_TWO) begin
            n_ax = sat32(r_px + r_nx);
            n_ay = sat32(r_py + r_ny);
            n_bx = sat32(r_px - r_nx);
            n_by = sat32(r_py - r_ny);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_f1_vld <= i_vld;
            r_strobe <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_cnt <= i_geo.count;
        r_px <= (i_geo.dx_neg ^ w_sub) ? (w_xe - w_off[0]) : (w_xe + w_off[0]);
        r_py <= (i_geo.dy_neg ^ w_sub) ? (w_ye - w_off[1]) : (w_ye + w_off[1]);
        r_nx <= i_geo.dy_pos ? (66'd0 - w_off[2]) : w_off[2];
        r_ny <= i_geo.dx_neg ? (66'd0 - w_off[3]) : w_off[3];

        r_cnt <= r_f1_cnt;
        r_ax  <= n_ax;
        r_ay  <= n_ay;
        r_bx  <= n_bx;
        r_by  <= n_by;
    end

    assign o_strobe      = r_strobe;
    assign o_point_count = r_cnt;
    assign o_point_a_x   = r_ax;
    assign o_point_a_y   = r_ay;
    assign o_point_b_x   = r_bx;
    assign o_point_b_y   = r_by;

endmodule

/* hdl/circle_pair_intersection_unit.sv */
// Top level: circle pair intersection, fully pipelined, one pair per clock.
//
// Usage:
//   Drive the two circles on the i_first_* and i_second_* ports and raise
//   start. A pair transfers at each rising edge where start is high and busy
//   is low. busy is low whenever reset is released, so a new pair may be
//   given in every cycle.
//   Each pair yields one result: o_strobe rises once the pair has passed
//   through every pipe stage and stays high for exactly one cycle, with
//   o_point_count and the point ports. The result transfers at the edge
//   that ends the strobe; the receiver cannot hold it off and the unit
//   never waits for it.
//   Throughput is one pair per cycle while reset is released. The pipe holds
//   eight front stages (squares, classification, K, Q), a row of 64 square root
//   cells, two multiply stages, a row of 64 divider cells (four quotients
//   by D in parallel), and two output stages.
//   Reset (synchronous, active low) empties the pipe; pairs in flight are
//   dropped and no strobe follows them.
module circle_pair_intersection_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_first_center_x,
    input  logic [31:0] i_first_center_y,
    input  logic [30:0] i_first_radius,
    input  logic [31:0] i_second_center_x,
    input  logic [31:0] i_second_center_y,
    input  logic [30:0] i_second_radius,
    output logic        o_strobe,
    output logic [1:0]  o_point_count,
    output logic [31:0] o_point_a_x,
    output logic [31:0] o_point_a_y,
    output logic [31:0] o_point_b_x,
    output logic [31:0] o_point_b_y
);
    import cpi_pkg::*;

    logic         w_take;
    logic [127:0] w_q;
    logic         w_sq_vld [0:LP_SQRT_STEPS];
    t_geo         w_sq_geo [0:LP_SQRT_STEPS];
    t_sqrt        w_sq_st  [0:LP_SQRT_STEPS];
    logic         w_dv_vld [0:LP_DIV_STEPS];
    t_geo         w_dv_geo [0:LP_DIV_STEPS];
    t_div         w_dv_st  [0:LP_DIV_STEPS];
    logic [32:0]  w_mag    [LP_NUM_DIVS];
    logic [63:0]  w_fac    [LP_NUM_DIVS];
    logic [96:0]  w_num    [LP_NUM_DIVS];
    logic         r_m1_vld, r_m2_vld;
    t_geo         r_m1_geo, r_m2_geo;
    logic [64:0]  r_m1_lo  [LP_NUM_DIVS];
    logic [64:0]  r_m1_hi  [LP_NUM_DIVS];
    t_div         r_m2_st;

    assign busy   = ~i_rst_n;
    assign w_take = start & ~busy;

    cpi_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (w_take),
        .i_x1   (i_first_center_x),
        .i_y1   (i_first_center_y),
        .i_r1   (i_first_radius),
        .i_x2   (i_second_center_x),
        .i_y2   (i_second_center_y),
        .i_r2   (i_second_radius),
        .o_vld  (w_sq_vld[0]),
        .o_geo  (w_sq_geo[0]),
        .o_q    (w_q)
    );

    assign w_sq_st[0] = '{rad: w_q, rem: '0, root: '0};

    for (genvar k = 0; k < LP_SQRT_STEPS; k++) begin : g_sq
        cpi_sqrt_cell u_sq (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (w_sq_vld[k]),
            .i_geo  (w_sq_geo[k]),
            .i_st   (w_sq_st[k]),
            .o_vld  (w_sq_vld[k+1]),
            .o_geo  (w_sq_geo[k+1]),
            .o_st   (w_sq_st[k+1])
        );
    end

    // numerators: |dx|*K, |dy|*K, |dy|*s, |dx|*s
    always_comb begin
        w_mag[0] = w_sq_geo[LP_SQRT_STEPS].dxm;
        w_mag[1] = w_sq_geo[LP_SQRT_STEPS].dym;
        w_mag[2] = w_sq_geo[LP_SQRT_STEPS].dym;
        w_mag[3] = w_sq_geo[LP_SQRT_STEPS].dxm;
        w_fac[0] = w_sq_geo[LP_SQRT_STEPS].kmag;
        w_fac[1] = w_sq_geo[LP_SQRT_STEPS].kmag;
        w_fac[2] = w_sq_st[LP_SQRT_STEPS].root;
        w_fac[3] = w_sq_st[LP_SQRT_STEPS].root;
        for (int j = 0; j < LP_NUM_DIVS; j++) begin
            w_num[j] = 97'(r_m1_lo[j]) + (97'(r_m1_hi[j]) << 32);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
        end else begin
            r_m1_vld <= w_sq_vld[LP_SQRT_STEPS];
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1_geo <= w_sq_geo[LP_SQRT_STEPS];
        r_m2_geo <= r_m1_geo;
        for (int j = 0; j < LP_NUM_DIVS; j++) begin
            r_m1_lo[j]    <= 65'(w_mag[j]) * 65'(w_fac[j][31:0]);
            r_m1_hi[j]    <= 65'(w_mag[j]) * 65'(w_fac[j][63:32]);
            r_m2_st.r[j]  <= 64'(w_num[j][96:64]);
            r_m2_st.nq[j] <= w_num[j][63:0];
        end
    end

    assign w_dv_vld[0] = r_m2_vld;
    assign w_dv_geo[0] = r_m2_geo;
    assign w_dv_st[0]  = r_m2_st;

    for (genvar k = 0; k < LP_DIV_STEPS; k++) begin : g_div
        cpi_div_cell u_div (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (w_dv_vld[k]),
            .i_geo  (w_dv_geo[k]),
            .i_st   (w_dv_st[k]),
            .o_vld  (w_dv_vld[k+1]),
            .o_geo  (w_dv_geo[k+1]),
            .o_st   (w_dv_st[k+1])
        );
    end

    cpi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (w_dv_vld[LP_DIV_STEPS]),
        .i_geo        (w_dv_geo[LP_DIV_STEPS]),
        .i_st         (w_dv_st[LP_DIV_STEPS]),
        .o_strobe     (o_strobe),
        .o_point_count(o_point_count),
        .o_point_a_x  (o_point_a_x),
        .o_point_a_y  (o_point_a_y),
        .o_point_b_x  (o_point_b_x),
        .o_point_b_y  (o_point_b_y)
    );

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> ##140 o_strobe)
        else $error("result strobe missing after transfer");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_point_count == CNT_NONE) |->
        (o_point_a_x == '0 && o_point_a_y == '0 && o_point_b_x == '0 && o_point_b_y == '0))
        else $error("points not cleared for empty result");

    a_one_b_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_point_count == CNT_ONE) |-> (o_point_b_x == '0 && o_point_b_y == '0))
        else $error("second point not cleared for touching circles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sq_vld[0] && !$past(w_take, 8)) |-> 1'b0)
        else $error("front end valid without a transfer");
`endif

endmodule
